// ===== hdl/gdcr_pkg.sv =====
package gdcr_pkg;

   localparam logic [1:0] MODE_HALT = 2'd1;
   localparam logic [1:0] MODE_TUNE = 2'd2;

   localparam logic [1:0] PAGE_BAR_TOP    = 2'd0;
   localparam logic [1:0] PAGE_BAR_BOTTOM = 2'd1;
   localparam logic [1:0] PAGE_TEXT       = 2'd2;
   localparam logic [1:0] PAGE_STATUS     = 2'd3;

   localparam logic [6:0] FIRST_COLUMN    = 7'd0;
   localparam logic [6:0] LAST_COLUMN     = 7'd127;
   localparam logic [6:0] STOP_TEXT_START = 7'd30;
   localparam logic [6:0] BAR_OFFSET      = 7'd3;
   localparam logic [6:0] BAR_SCALE       = 7'd120;

   localparam int PIPE_DEPTH = 3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  page;
      logic [6:0]  column;
      logic [6:0]  bar_end;
      logic [6:0]  marker;
      logic [11:0] speed_bcd;
      logic [11:0] target_bcd;
   } s1_type;

   typedef struct packed {
      logic       use_glyph;
      logic [5:0] slot;
      logic [2:0] gcol;
      logic       invert;
      logic [7:0] fill;
   } s2_type;

   function automatic logic [11:0] to_bcd(input logic [7:0] value);
      logic [19:0] sh;
      int n;
      sh = {12'd0, value};
      for (n = 0; n < 8; n++) begin
         if (sh[11:8] >= 4'd5) begin
            sh[11:8] = sh[11:8] + 4'd3;
         end
         if (sh[15:12] >= 4'd5) begin
            sh[15:12] = sh[15:12] + 4'd3;
         end
         if (sh[19:16] >= 4'd5) begin
            sh[19:16] = sh[19:16] + 4'd3;
         end
         sh = sh << 1;
      end
      return sh[19:8];
   endfunction

   // Scales 0..255 to 0..120 and adds the border offset; x/255 is formed as
   // (x + x/256 + 1)/256, which is exact for every product that can occur here.
   function automatic logic [6:0] scale_column(input logic [7:0] value);
      logic [14:0] prod;
      logic [15:0] sum;
      prod = 15'(value) * 15'(BAR_SCALE);
      sum  = 16'(prod) + 16'(prod[14:8]) + 16'd1;
      return sum[14:8] + BAR_OFFSET;
   endfunction

   function automatic logic [7:0] glyph_column(input logic [5:0] slot, input logic [2:0] gcol);
      logic [39:0] row;
      case (slot)
         6'd1:    row = {8'h00, 8'h00, 8'h00, 8'h5F, 8'h00};
         6'd2:    row = {8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
         6'd3:    row = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
         6'd4:    row = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
         6'd5:    row = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
         6'd6:    row = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
         6'd7:    row = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
         6'd8:    row = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
         6'd9:    row = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         6'd10:   row = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         6'd11:   row = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
         6'd12:   row = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
         6'd13:   row = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
         6'd14:   row = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         6'd15:   row = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
         6'd16:   row = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         6'd17:   row = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
         6'd18:   row = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
         6'd19:   row = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
         6'd20:   row = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
         6'd21:   row = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         6'd22:   row = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         6'd23:   row = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
         6'd24:   row = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
         6'd25:   row = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
         6'd26:   row = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
         6'd27:   row = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
         6'd28:   row = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         6'd29:   row = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         6'd30:   row = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         6'd31:   row = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
         6'd32:   row = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         6'd33:   row = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         6'd34:   row = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         6'd35:   row = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         6'd36:   row = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         6'd37:   row = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         6'd38:   row = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
         6'd39:   row = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         6'd40:   row = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
         6'd41:   row = {8'h41, 8'h22, 8'h14, 8'h08, 8'h00};
         default: row = 40'd0;
      endcase
      if (gcol >= 3'd5) begin
         return 8'h00;
      end
      return row[{gcol, 3'b000} +: 8];
   endfunction

endpackage

// ===== hdl/gdcr_locate.sv =====
module gdcr_locate (
   input  gdcr_pkg::s1_type s1,
   output gdcr_pkg::s2_type s2
);

   typedef enum logic [2:0] {
      STR_SPD,
      STR_SPEED_NUM,
      STR_TGT,
      STR_TARGET_NUM,
      STR_STOP,
      STR_TUNE,
      STR_KP,
      STR_CRUISE
   } str_type;

   localparam logic [5:0] SLOT_DIGIT0 = 6'd28;

   localparam logic [7:0] FILL_FULL   = 8'hFF;
   localparam logic [7:0] FILL_MARKER = 8'hAA;
   localparam logic [7:0] FILL_TOP_STOP  = 8'h18;
   localparam logic [7:0] FILL_TOP_DOT   = 8'h10;
   localparam logic [7:0] FILL_LOW_STOP  = 8'h03;
   localparam logic [7:0] FILL_LOW_BAR   = 8'h07;
   localparam logic [7:0] FILL_LOW_DOT   = 8'h01;
   localparam logic [7:0] FILL_NONE      = 8'h00;

   localparam logic [5:0] SPD_TEXT [16] = '{6'd20, 6'd17, 6'd5, 6'd38, 6'd0, 6'd0, 6'd0, 6'd0,
                                            6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam logic [5:0] TGT_TEXT [16] = '{6'd21, 6'd8, 6'd21, 6'd38, 6'd0, 6'd0, 6'd0, 6'd0,
                                            6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam logic [5:0] STOP_TEXT [16] = '{6'd6, 6'd14, 6'd6, 6'd19, 6'd8, 6'd6, 6'd15, 6'd4,
                                             6'd26, 6'd0, 6'd20, 6'd21, 6'd16, 6'd17, 6'd0, 6'd0};
   localparam logic [5:0] TUNE_TEXT [16] = '{6'd21, 6'd22, 6'd15, 6'd6, 6'd0, 6'd12, 6'd17, 6'd38,
                                             6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam logic [5:0] KP_TEXT [16] = '{6'd12, 6'd17, 6'd38, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
                                           6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam logic [5:0] CRUISE_TEXT [16] = '{6'd4, 6'd19, 6'd22, 6'd10, 6'd20, 6'd6, 6'd0, 6'd4,
                                               6'd21, 6'd19, 6'd13, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};

   function automatic logic [5:0] digit_slot(input logic [11:0] bcd, input logic [4:0] k);
      logic [3:0] d;
      case (k)
         5'd0:    d = bcd[11:8];
         5'd1:    d = bcd[7:4];
         default: d = bcd[3:0];
      endcase
      return SLOT_DIGIT0 + {2'b00, d};
   endfunction

   logic        stop;
   logic        tune;
   logic [7:0]  bar_fill;
   str_type     str;
   logic [6:0]  start;
   logic [6:0]  span;
   logic [6:0]  off;
   logic [12:0] kprod;
   logic [4:0]  k;
   logic [6:0]  k6;
   logic [6:0]  gcol_full;
   logic        hit;
   logic [5:0]  slot;
   logic        text_page;

   assign stop = (s1.mode == gdcr_pkg::MODE_HALT);
   assign tune = (s1.mode == gdcr_pkg::MODE_TUNE);
   assign text_page = (s1.page == gdcr_pkg::PAGE_TEXT) || (s1.page == gdcr_pkg::PAGE_STATUS);

   always_comb begin
      if (s1.column == gdcr_pkg::FIRST_COLUMN || s1.column == gdcr_pkg::LAST_COLUMN) begin
         bar_fill = FILL_FULL;
      end else if (s1.page == gdcr_pkg::PAGE_BAR_TOP) begin
         if (s1.column == s1.marker) begin
            bar_fill = FILL_MARKER;
         end else if (s1.column <= s1.bar_end) begin
            bar_fill = stop ? FILL_TOP_STOP : FILL_FULL;
         end else begin
            bar_fill = (s1.column[1:0] == 2'b00) ? FILL_TOP_DOT : FILL_NONE;
         end
      end else begin
         if (s1.column <= s1.bar_end) begin
            bar_fill = stop ? FILL_LOW_STOP : FILL_LOW_BAR;
         end else begin
            bar_fill = (s1.column[1:0] == 2'b00) ? FILL_LOW_DOT : FILL_NONE;
         end
      end
   end

   always_comb begin
      str   = STR_SPD;
      start = 7'd0;
      span  = 7'd24;
      if (s1.page == gdcr_pkg::PAGE_TEXT) begin
         if (stop) begin
            str   = STR_STOP;
            start = gdcr_pkg::STOP_TEXT_START;
            span  = 7'd84;
         end else if (tune) begin
            str   = STR_TUNE;
            span  = 7'd48;
         end else if (s1.column < 7'd26) begin
            str   = STR_SPD;
         end else if (s1.column < 7'd48) begin
            str   = STR_SPEED_NUM;
            start = 7'd26;
            span  = 7'd18;
         end else if (s1.column < 7'd74) begin
            str   = STR_TGT;
            start = 7'd48;
         end else begin
            str   = STR_TARGET_NUM;
            start = 7'd74;
            span  = 7'd18;
         end
      end else if (tune) begin
         str  = STR_KP;
         span = 7'd18;
      end else begin
         str  = STR_CRUISE;
         span = 7'd66;
      end
   end

   // Character index is off/6, taken as off*43/256, exact for off below 128.
   assign off       = s1.column - start;
   assign kprod     = 13'(off) * 13'd43;
   assign k         = kprod[12:8];
   assign k6        = 7'(k) * 7'd6;
   assign gcol_full = off - k6;
   assign hit       = (s1.column >= start) && (off < span);

   always_comb begin
      case (str)
         STR_SPD:        slot = SPD_TEXT[k[3:0]];
         STR_SPEED_NUM:  slot = digit_slot(s1.speed_bcd, k);
         STR_TGT:        slot = TGT_TEXT[k[3:0]];
         STR_TARGET_NUM: slot = digit_slot(s1.target_bcd, k);
         STR_STOP:       slot = STOP_TEXT[k[3:0]];
         STR_TUNE:       slot = TUNE_TEXT[k[3:0]];
         STR_KP:         slot = KP_TEXT[k[3:0]];
         STR_CRUISE:     slot = CRUISE_TEXT[k[3:0]];
         default:        slot = 6'd0;
      endcase
   end

   always_comb begin
      s2.use_glyph = text_page && hit;
      s2.slot      = slot;
      s2.gcol      = gcol_full[2:0];
      s2.invert    = (str == STR_STOP);
      if (text_page) begin
         s2.fill = (str == STR_STOP) ? FILL_FULL : FILL_NONE;
      end else begin
         s2.fill = bar_fill;
      end
   end

endmodule

// ===== hdl/gauge_display_column_renderer_core.sv =====
// Renders one 8-pixel column byte of a 128x32 page-mode gauge display for the
// requested page and column, from the speed, target and mode given with it. A
// request beat is taken on every cycle in which start is high, since busy is
// never raised; the matching result passes s1_ff, s2_ff and rsp_pixels_ff and
// appears on rsp_pixels with rsp_valid high for one cycle, in request order.
// The three stages are bar scaling and decimal conversion, text placement,
// and font lookup, so one column byte leaves per clock. Results cannot be
// held off, so the receiver must take every beat on the cycle it is shown.
module gauge_display_column_renderer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_speed,
   input  logic [7:0] req_target,
   input  logic [1:0] req_mode,
   input  logic [1:0] req_page,
   input  logic [6:0] req_column,
   output logic       rsp_valid,
   output logic [7:0] rsp_pixels
);

   logic             s1_valid_ff;
   gdcr_pkg::s1_type s1_ff;
   gdcr_pkg::s1_type s1_in;
   logic             s2_valid_ff;
   gdcr_pkg::s2_type s2_ff;
   gdcr_pkg::s2_type s2_in;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_pixels_ff;
   logic [7:0]       rsp_pixels_in;
   logic [7:0]       glyph;

   assign busy = 1'b0;

   always_comb begin
      s1_in.mode       = req_mode;
      s1_in.page       = req_page;
      s1_in.column     = req_column;
      s1_in.bar_end    = gdcr_pkg::scale_column(req_speed);
      s1_in.marker     = gdcr_pkg::scale_column(req_target);
      s1_in.speed_bcd  = gdcr_pkg::to_bcd(req_speed);
      s1_in.target_bcd = gdcr_pkg::to_bcd(req_target);
   end

   gdcr_locate u_locate (
      .s1 (s1_ff),
      .s2 (s2_in)
   );

   assign glyph         = gdcr_pkg::glyph_column(s2_ff.slot, s2_ff.gcol);
   assign rsp_pixels_in = s2_ff.use_glyph ? (glyph ^ {8{s2_ff.invert}}) : s2_ff.fill;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      rsp_pixels_ff <= rsp_pixels_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pixels = rsp_pixels_ff;

`ifndef SYNTHESIS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, gdcr_pkg::PIPE_DEPTH))
      else $error("Result beat without a request beat three cycles earlier.");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      start |-> ##3 rsp_valid)
      else $error("Request beat lost in the pipeline.");

   a_border_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_page, gdcr_pkg::PIPE_DEPTH) == gdcr_pkg::PAGE_BAR_TOP
      && $past(req_column, gdcr_pkg::PIPE_DEPTH) == gdcr_pkg::FIRST_COLUMN
      |-> rsp_pixels == 8'hFF)
      else $error("Bar border column not fully lit.");

   a_stop_background: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_page, gdcr_pkg::PIPE_DEPTH) == gdcr_pkg::PAGE_TEXT
      && $past(req_mode, gdcr_pkg::PIPE_DEPTH) == gdcr_pkg::MODE_HALT
      && $past(req_column, gdcr_pkg::PIPE_DEPTH) < gdcr_pkg::STOP_TEXT_START
      |-> rsp_pixels == 8'hFF)
      else $error("Stop banner background not white left of the text.");
`endif

endmodule
